// ----- rtl/olir_pkg.sv -----
package olir_pkg;

    localparam int DEPTH_DEF  = 16;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 5;
    localparam int KEY_W      = 32;
    localparam int HANDLE_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET_KEY    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_POS    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_KEY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_POS = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 2'd3;

endpackage

// ----- rtl/olir_req_if.sv -----
interface olir_req_if;
    import olir_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, cmd, position, key, handle, input ready);
    modport sink   (input valid, cmd, position, key, handle, output ready);
endinterface

// ----- rtl/olir_rsp_if.sv -----
interface olir_rsp_if;
    import olir_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, status, handle_out, count, input ready);
    modport sink   (input valid, status, handle_out, count, output ready);
endinterface

// ----- rtl/ordered_list_insert_remove.sv -----
// Bounded ordered list of up to DEPTH entries, each a key with a handle.
// Request channel i_req carries cmd, position, key and handle; response
// channel o_rsp returns status, handle_out and the entry count after the
// operation. Every request gives exactly one response, in order.
// Entries sit in a single-port-write, single-port-read memory with a
// registered read, walked by one index counter under a small sequencer.
// A rejected request goes from decode straight to the finish state. A get
// by position reads the entry once and an append writes it at once; insert
// and remove by position shift the entries behind the position one by one,
// and a key search reads and compares the entries one by one. Scan and
// shift of a remove by key cover the list once. Each entry step is a read
// state followed by a write or compare state, as the memory read is registered.
// One request is worked on at a time: i_req.ready is high only while idle,
// so a new request is taken only once the previous operation has finished.
// The response waits in an output register; a new request is taken while
// it waits, and the sequencer holds its finished result if the register is
// still occupied when the next operation completes.
// Reset (synchronous, active low) empties the list and drops any response.
module ordered_list_insert_remove #(
    parameter int DEPTH = olir_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    olir_req_if.sink    i_req,
    olir_rsp_if.source  o_rsp
);
    import olir_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = (CW > POS_W) ? CW : POS_W;
    localparam int DW = KEY_W + HANDLE_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_UP_RD    = 4'd2;
    localparam logic [3:0] S_UP_WR    = 4'd3;
    localparam logic [3:0] S_INS      = 4'd4;
    localparam logic [3:0] S_KEY_RD   = 4'd5;
    localparam logic [3:0] S_KEY_CMP  = 4'd6;
    localparam logic [3:0] S_POS_WAIT = 4'd7;
    localparam logic [3:0] S_DN_RD    = 4'd8;
    localparam logic [3:0] S_DN_WR    = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [W-1:0]        r_pos, n_pos;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_hout, n_hout;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [DW-1:0]       r_mem [DEPTH];
    logic [DW-1:0]       r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_wdata;

    logic [W-1:0]        count_w;

    assign count_w = W'(r_count);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pos        = r_pos;
        n_key        = r_key;
        n_handle     = r_handle;
        n_count      = r_count;
        n_idx        = r_idx;
        n_status     = r_status;
        n_hout       = r_hout;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_raddr    = r_idx[AW-1:0];
        mem_wdata    = r_rdata;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd    = i_req.cmd;
                    n_pos    = W'(i_req.position);
                    n_key    = i_req.key;
                    n_handle = i_req.handle;
                    n_hout   = '0;
                    n_status = ST_OK;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_cmd) inside
                    CMD_APPEND, CMD_INSERT: begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else if (r_cmd == CMD_INSERT && r_pos > count_w) begin
                            n_status = ST_RANGE;
                            n_state  = S_FIN;
                        end else begin
                            if (r_cmd == CMD_APPEND) begin
                                n_pos = count_w;
                            end
                            n_idx = r_count;
                            if (r_cmd == CMD_INSERT && count_w > r_pos) begin
                                n_state = S_UP_RD;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                    end
                    CMD_GET_KEY, CMD_REMOVE_KEY: begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_status = ST_NOKEY;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_KEY_RD;
                        end
                    end
                    CMD_GET_POS, CMD_REMOVE_POS: begin
                        if (r_pos >= count_w) begin
                            n_status = ST_RANGE;
                            n_state  = S_FIN;
                        end else begin
                            n_idx     = r_pos[CW-1:0];
                            mem_raddr = r_pos[AW-1:0];
                            n_state   = S_POS_WAIT;
                        end
                    end
                    default: begin
                        n_status = ST_RANGE;
                        n_state  = S_FIN;
                    end
                endcase
            end
            // shift up: copy entry idx-1 into idx, down to the insert point
            S_UP_RD: begin
                mem_raddr = AW'(r_idx - CW'(1));
                n_state   = S_UP_WR;
            end
            S_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = r_idx - CW'(1);
                if (W'(r_idx - CW'(1)) > r_pos) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = {r_key, r_handle};
                n_count   = r_count + CW'(1);
                n_status  = ST_OK;
                n_state   = S_FIN;
            end
            S_KEY_RD: begin
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_KEY_CMP;
            end
            S_KEY_CMP: begin
                if (r_rdata[DW-1:HANDLE_W] == r_key) begin
                    n_hout   = r_rdata[HANDLE_W-1:0];
                    n_status = ST_OK;
                    if (r_cmd == CMD_GET_KEY) begin
                        n_state = S_FIN;
                    end else if (r_idx + CW'(1) < r_count) begin
                        n_state = S_DN_RD;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_FIN;
                    end
                end else if (r_idx + CW'(1) >= r_count) begin
                    n_status = ST_NOKEY;
                    n_state  = S_FIN;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_KEY_RD;
                end
            end
            S_POS_WAIT: begin
                n_hout   = r_rdata[HANDLE_W-1:0];
                n_status = ST_OK;
                if (r_cmd == CMD_GET_POS) begin
                    n_state = S_FIN;
                end else if (r_idx + CW'(1) < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            // shift down: copy entry idx+1 into idx up to the last entry
            S_DN_RD: begin
                mem_raddr = AW'(r_idx + CW'(1));
                n_state   = S_DN_WR;
            end
            S_DN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = r_idx + CW'(1);
                if (r_idx + CW'(2) < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_handle = (r_status == ST_OK) ? r_hout : '0;
                    n_out_count  = count_w[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_handle     <= n_handle;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_hout       <= n_hout;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_count  <= n_out_count;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.count      = r_out_count;

endmodule
